// ===== src/scl_pkg.sv =====
package scl_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_CLOSED = 2'd1;
  localparam logic [1:0] KIND_EOL    = 2'd2;

  // Token types
  localparam logic [2:0] T_WORD   = 3'd0;
  localparam logic [2:0] T_PIPE   = 3'd1;
  localparam logic [2:0] T_IN     = 3'd2;
  localparam logic [2:0] T_OUT    = 3'd3;
  localparam logic [2:0] T_APPEND = 3'd4;
  localparam logic [2:0] T_SEMI   = 3'd5;
  localparam logic [2:0] T_AMP    = 3'd6;
  localparam logic [2:0] T_EOF    = 3'd7;

  // Lexer modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_WORD   = 2'd1;
  localparam logic [1:0] MODE_QUOTED = 2'd2;

  // Bytes of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [6:0] TOKEN_LIMIT_RESET = 7'd100;
  localparam int         QUEUE_DEPTH       = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] token_type;
    logic [7:0] byte_out;
    logic [6:0] token_index;
  } result_t;

  // All results caused by one input byte
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } run_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT) || (c == CH_SEMI) ||
           (c == CH_AMP);
  endfunction

endpackage

// ===== src/scl_front.sv =====
module scl_front import scl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [6:0] token_limit,
  input  logic       in_fire,
  input  logic [7:0] ch,
  input  logic       end_of_line,
  output logic       run_valid,
  output run_t       run
);

  logic [1:0] lex_mode, lex_mode_next;
  logic       double_quoted, double_quoted_next;
  logic       escape_pending, escape_pending_next;
  logic       greater_pending, greater_pending_next;
  logic [6:0] tokens_made, tokens_made_next;

  // what starting a token with ch would do
  logic       st_has;
  result_t    st_res;
  logic [1:0] st_mode;
  logic       st_dq, st_esc, st_gt;
  logic [6:0] st_tm;
  logic       room;

  always_comb begin
    room    = ({1'b0, tokens_made} + 8'd1) < {1'b0, token_limit};
    st_has  = 1'b0;
    st_res  = '0;
    st_mode = MODE_IDLE;
    st_dq   = double_quoted;
    st_esc  = escape_pending;
    st_gt   = 1'b0;
    st_tm   = tokens_made;
    if (!is_space(ch) && room) begin
      st_tm = tokens_made + 7'd1;
      case (ch)
        CH_PIPE: begin
          st_has = 1'b1;
          st_res = '{KIND_CLOSED, T_PIPE, 8'd0, tokens_made};
        end
        CH_LT: begin
          st_has = 1'b1;
          st_res = '{KIND_CLOSED, T_IN, 8'd0, tokens_made};
        end
        CH_SEMI: begin
          st_has = 1'b1;
          st_res = '{KIND_CLOSED, T_SEMI, 8'd0, tokens_made};
        end
        CH_AMP: begin
          st_has = 1'b1;
          st_res = '{KIND_CLOSED, T_AMP, 8'd0, tokens_made};
        end
        CH_GT: st_gt = 1'b1;
        CH_SQUOTE: begin
          st_mode = MODE_QUOTED;
          st_dq   = 1'b0;
          st_esc  = 1'b0;
        end
        CH_DQUOTE: begin
          st_mode = MODE_QUOTED;
          st_dq   = 1'b1;
          st_esc  = 1'b0;
        end
        default: begin
          st_mode = MODE_WORD;
          st_has  = 1'b1;
          st_res  = '{KIND_BYTE, T_WORD, ch, tokens_made};
        end
      endcase
    end
  end

  logic       a_has, b_has;
  result_t    a_res, b_res;
  logic [6:0] cur_idx;
  logic [7:0] quote_ch;

  always_comb begin
    cur_idx              = tokens_made - 7'd1;
    quote_ch             = double_quoted ? CH_DQUOTE : CH_SQUOTE;
    a_has                = 1'b0;
    a_res                = '0;
    b_has                = 1'b0;
    b_res                = '0;
    lex_mode_next        = lex_mode;
    double_quoted_next   = double_quoted;
    escape_pending_next  = escape_pending;
    greater_pending_next = greater_pending;
    tokens_made_next     = tokens_made;

    if (end_of_line) begin
      a_has = greater_pending || (lex_mode == MODE_WORD) || (lex_mode == MODE_QUOTED);
      a_res = '{KIND_CLOSED, (greater_pending ? T_OUT : T_WORD), 8'd0, cur_idx};
      b_has = 1'b1;
      b_res = '{KIND_EOL, T_EOF, 8'd0, tokens_made};
      lex_mode_next        = MODE_IDLE;
      double_quoted_next   = 1'b0;
      escape_pending_next  = 1'b0;
      greater_pending_next = 1'b0;
      tokens_made_next     = '0;
    end else if (ch != CH_NUL) begin
      if (greater_pending) begin
        greater_pending_next = 1'b0;
        a_has = 1'b1;
        if (ch == CH_GT) begin
          a_res = '{KIND_CLOSED, T_APPEND, 8'd0, cur_idx};
        end else begin
          a_res                = '{KIND_CLOSED, T_OUT, 8'd0, cur_idx};
          b_has                = st_has;
          b_res                = st_res;
          lex_mode_next        = st_mode;
          double_quoted_next   = st_dq;
          escape_pending_next  = st_esc;
          greater_pending_next = st_gt;
          tokens_made_next     = st_tm;
        end
      end else if (lex_mode == MODE_WORD) begin
        a_has = 1'b1;
        if (is_space(ch) || is_op(ch)) begin
          a_res                = '{KIND_CLOSED, T_WORD, 8'd0, cur_idx};
          b_has                = st_has;
          b_res                = st_res;
          lex_mode_next        = st_mode;
          double_quoted_next   = st_dq;
          escape_pending_next  = st_esc;
          greater_pending_next = st_gt;
          tokens_made_next     = st_tm;
        end else begin
          a_res = '{KIND_BYTE, T_WORD, ch, cur_idx};
        end
      end else if (lex_mode == MODE_QUOTED) begin
        a_has = 1'b1;
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          a_res = '{KIND_BYTE, T_WORD, ch, cur_idx};
        end else if (ch == quote_ch) begin
          a_res              = '{KIND_CLOSED, T_WORD, 8'd0, cur_idx};
          lex_mode_next      = MODE_IDLE;
          double_quoted_next = 1'b0;
        end else begin
          escape_pending_next = (ch == CH_BSLASH);
          a_res = '{KIND_BYTE, T_WORD, ch, cur_idx};
        end
      end else begin
        // idle, and the unused mode code
        b_has                = st_has;
        b_res                = st_res;
        lex_mode_next        = st_mode;
        double_quoted_next   = st_dq;
        escape_pending_next  = st_esc;
        greater_pending_next = st_gt;
        tokens_made_next     = st_tm;
      end
    end
  end

  // pack the (up to two) results in order
  always_comb begin
    run_valid = a_has || b_has;
    run.two   = a_has && b_has;
    run.r0    = a_has ? a_res : b_res;
    run.r1    = b_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode        <= MODE_IDLE;
      double_quoted   <= 1'b0;
      escape_pending  <= 1'b0;
      greater_pending <= 1'b0;
      tokens_made     <= '0;
    end else if (in_fire) begin
      lex_mode        <= lex_mode_next;
      double_quoted   <= double_quoted_next;
      escape_pending  <= escape_pending_next;
      greater_pending <= greater_pending_next;
      tokens_made     <= tokens_made_next;
    end
  end

endmodule

// ===== src/scl_queue.sv =====
module scl_queue import scl_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  run_t push_data,
  input  logic pop,
  output run_t pop_data,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/scl_back.sv =====
module scl_back import scl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  run_t       q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [2:0] token_type,
  output logic [7:0] byte_out,
  output logic [6:0] token_index,
  output logic       last_of_run
);

  logic    busy;
  logic    phase;  // 0: first result of the run, 1: second
  run_t    cur;
  result_t sel;
  logic    done;

  assign sel         = phase ? cur.r1 : cur.r0;
  assign out_valid   = busy;
  assign kind        = sel.kind;
  assign token_type  = sel.token_type;
  assign byte_out    = sel.byte_out;
  assign token_index = sel.token_index;
  assign last_of_run = !cur.two || phase;

  // run finished this cycle, or nothing held
  assign done  = !busy || (out_ready && last_of_run);
  assign q_pop = done && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (done) begin
      busy  <= !q_empty;
      phase <= 1'b0;
    end else if (out_ready) begin
      phase <= 1'b1;
    end
  end

endmodule

// ===== src/shell_command_lexer.sv =====
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    ch[7:0], end_of_line
// result    out        out_valid / out_ready  kind[1:0], token_type[2:0], byte_out[7:0],
//                                             token_index[6:0], last_of_run
// config    in         cfg_write (no wait)    cfg_data[6:0] -> token_limit
//
// One input byte is taken per cycle while the run queue has room; each byte gives
// zero, one or two results; while out_ready is high the result port delivers one result
// per cycle. From an input transfer to its first result, the run is written into the
// queue and then loaded into the output register.
// rst is synchronous: lexer state and queue cleared, token_limit back to 100.
// A stalled result port fills the run queue (QUEUE_DEPTH runs), then in_ready drops.
module shell_command_lexer import scl_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [2:0] token_type,
  output logic [7:0] byte_out,
  output logic [6:0] token_index,
  output logic       last_of_run
);

  logic [6:0] token_limit;
  logic       in_fire;
  logic       run_valid;
  run_t       run;
  logic       q_push, q_pop, q_full, q_empty;
  run_t       q_data;

  // limit register; the user writes it only between lines, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      token_limit <= TOKEN_LIMIT_RESET;
    end else if (cfg_write) begin
      token_limit <= cfg_data;
    end
  end

  // front takes a byte whenever there is a free slot, whatever the back is doing
  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;
  // bytes that cause nothing (NUL, separators, ignored bytes) use no slot
  assign q_push   = in_fire && run_valid;

  scl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .token_limit (token_limit),
    .in_fire     (in_fire),
    .ch          (ch),
    .end_of_line (end_of_line),
    .run_valid   (run_valid),
    .run         (run)
  );

  scl_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (run),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back serialises each run, first result then second
  scl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .token_type  (token_type),
    .byte_out    (byte_out),
    .token_index (token_index),
    .last_of_run (last_of_run)
  );

  // queue never written while full
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("run queue written while full");

  // end of line always closes its run
  a_eol_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_EOL)) |-> (last_of_run && (token_type == T_EOF)))
    else $error("end-of-line result not last of run");

  // word bytes are typed as words; other kinds carry no byte
  a_byte_field : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_BYTE) ? (token_type == T_WORD) : (byte_out == 8'd0)))
    else $error("byte field inconsistent with kind");

  // a run taken from the queue is on the result port the next cycle
  a_queue_to_port : assert property (@(posedge clk) disable iff (rst)
    (q_pop && !$past(rst)) |=> out_valid)
    else $error("run loaded without result shown");

endmodule
